@@ design/bbcr_pkg.sv @@
package bbcr_pkg;

  localparam int unsigned MaxWidth  = 128;
  localparam int unsigned MaxHeight = 128;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned AddrW     = ColW + RowW;
  localparam int unsigned Depth     = MaxWidth * MaxHeight;
  localparam int unsigned DimW      = 8;
  localparam int unsigned PixW      = 24;
  localparam int unsigned CfgIdxW   = 8;

  localparam logic [DimW-1:0] DimMaxW = DimW'(MaxWidth);
  localparam logic [DimW-1:0] DimMaxH = DimW'(MaxHeight);

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegFrameHeight = CfgIdxW'(1);

  localparam logic [7:0]      ColorMax = 8'd255;
  localparam logic [PixW-1:0] White    = {ColorMax, ColorMax, ColorMax};
  localparam logic [PixW-1:0] Green    = {8'd0, ColorMax, 8'd0};
  localparam logic [PixW-1:0] Black    = '0;

  localparam logic OpPush = 1'b0;
  localparam logic OpPull = 1'b1;

  typedef enum logic [1:0] {
    StatusOk         = 2'd0,
    StatusIncomplete = 2'd1,
    StatusEmpty      = 2'd2,
    StatusDrained    = 2'd3
  } status_e;

  typedef enum logic {
    CtrlIdle = 1'b0,
    CtrlRead = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic push;
    logic pull;
    logic load_out;
  } cmd_t;

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, logic [DimW-1:0] max);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > max) begin
      r = max;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [PixW-1:0] recolor(logic [PixW-1:0] p);
    logic [PixW-1:0] r;
    if (p == Green || p == Black) begin
      r = White;
    end else if (p == White) begin
      r = Black;
    end else begin
      r = p;
    end
    return r;
  endfunction

endpackage

@@ design/bbcr_if.sv @@
interface bbcr_in_if import bbcr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            op;
  logic [PixW-1:0] pixel;

  modport source (output valid, op, pixel, input ready);
  modport sink (input valid, op, pixel, output ready);
endinterface

interface bbcr_out_if import bbcr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] out_pixel;
  logic [ColW-1:0] out_x;
  logic [RowW-1:0] out_y;
  logic            last;
  logic [DimW-1:0] crop_width;
  logic [DimW-1:0] crop_height;
  logic [1:0]      status;

  modport source (output valid, out_pixel, out_x, out_y, last, crop_width, crop_height,
                  status, input ready);
  modport sink (input valid, out_pixel, out_x, out_y, last, crop_width, crop_height,
                status, output ready);
endinterface

interface bbcr_cfg_if import bbcr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DimW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/bbcr_ram.sv @@
module bbcr_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bbcr_ctrl.sv @@
module bbcr_ctrl import bbcr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_op_i,
  input  logic out_ready_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  // a pull needs the output register free by the time its data arrives
  assign in_ready_o  = (state_q == CtrlIdle) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CtrlIdle: begin
        if (accept && in_op_i == OpPull) begin
          state_d = CtrlRead;
        end
      end
      CtrlRead: state_d = CtrlIdle;
      default:  state_d = CtrlIdle;
    endcase
  end

  always_comb begin
    cmd_o.push     = accept && (in_op_i == OpPush);
    cmd_o.pull     = accept && (in_op_i == OpPull);
    cmd_o.load_out = (state_q == CtrlRead);
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CtrlIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/bbcr_datapath.sv @@
module bbcr_datapath import bbcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [PixW-1:0]    pixel_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  output logic [PixW-1:0]    out_pixel_o,
  output logic [ColW-1:0]    out_x_o,
  output logic [RowW-1:0]    out_y_o,
  output logic               out_last_o,
  output logic [DimW-1:0]    crop_width_o,
  output logic [DimW-1:0]    crop_height_o,
  output status_e            status_o
);

  logic [DimW-1:0] width_q, height_q;
  logic [ColW-1:0] wr_col_q, box_left_q, box_right_q, rd_col_q;
  logic [RowW-1:0] wr_row_q, box_top_q, box_bottom_q, rd_row_q;
  logic            full_q, found_q, rd_done_q;

  // result of the accepted pull, waiting for the store read
  status_e         pend_status_q;
  logic [ColW-1:0] pend_x_q;
  logic [RowW-1:0] pend_y_q;
  logic            pend_last_q;
  logic [DimW-1:0] pend_cw_q, pend_ch_q;

  logic [PixW-1:0] out_pixel_q;
  logic [ColW-1:0] out_x_q;
  logic [RowW-1:0] out_y_q;
  logic            out_last_q;
  logic [DimW-1:0] out_cw_q, out_ch_q;
  status_e         out_status_q;

  logic [ColW-1:0] last_col;
  logic [RowW-1:0] last_row;
  logic [ColW-1:0] col;
  logic [RowW-1:0] row;
  logic            found_eff, is_white, cfg_hit;
  logic [DimW-1:0] cw, ch, new_w, new_h;
  logic [ColW-1:0] rd_abs_col;
  logic [RowW-1:0] rd_abs_row;
  logic            col_end, row_end;
  status_e         pull_status;
  logic [PixW-1:0] ram_rdata;

  assign last_col = ColW'(width_q - DimW'(1));
  assign last_row = RowW'(height_q - DimW'(1));

  // a push after a complete frame starts the next frame at the origin
  assign col       = full_q ? '0 : wr_col_q;
  assign row       = full_q ? '0 : wr_row_q;
  assign found_eff = found_q && !full_q;
  assign is_white  = (pixel_i == White);

  assign cw         = DimW'(box_right_q - box_left_q) + DimW'(1);
  assign ch         = DimW'(box_bottom_q - box_top_q) + DimW'(1);
  assign rd_abs_col = box_left_q + rd_col_q;
  assign rd_abs_row = box_top_q + rd_row_q;
  assign col_end    = (rd_abs_col == box_right_q);
  assign row_end    = (rd_abs_row == box_bottom_q);

  always_comb begin
    priority if (!full_q) begin
      pull_status = StatusIncomplete;
    end else if (!found_q) begin
      pull_status = StatusEmpty;
    end else if (rd_done_q) begin
      pull_status = StatusDrained;
    end else begin
      pull_status = StatusOk;
    end
  end

  assign cfg_hit = cfg_we_i && (cfg_index_i == RegFrameWidth || cfg_index_i == RegFrameHeight);
  assign new_w   = (cfg_we_i && cfg_index_i == RegFrameWidth) ?
                   clamp_dim(cfg_data_i, DimMaxW) : width_q;
  assign new_h   = (cfg_we_i && cfg_index_i == RegFrameHeight) ?
                   clamp_dim(cfg_data_i, DimMaxH) : height_q;

  bbcr_ram #(
    .Width (PixW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i ({row, col}),
    .wdata_i (pixel_i),
    .re_i    (cmd_i.pull),
    .raddr_i ({rd_abs_row, rd_abs_col}),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= DimMaxW;
      height_q     <= DimMaxH;
      wr_col_q     <= '0;
      wr_row_q     <= '0;
      full_q       <= 1'b0;
      found_q      <= 1'b0;
      box_top_q    <= RowW'(DimMaxH - DimW'(1));
      box_bottom_q <= '0;
      box_left_q   <= ColW'(DimMaxW - DimW'(1));
      box_right_q  <= '0;
      rd_col_q     <= '0;
      rd_row_q     <= '0;
      rd_done_q    <= 1'b0;
    end else if (cfg_hit) begin
      width_q      <= new_w;
      height_q     <= new_h;
      wr_col_q     <= '0;
      wr_row_q     <= '0;
      full_q       <= 1'b0;
      found_q      <= 1'b0;
      box_top_q    <= RowW'(new_h - DimW'(1));
      box_bottom_q <= '0;
      box_left_q   <= ColW'(new_w - DimW'(1));
      box_right_q  <= '0;
      rd_col_q     <= '0;
      rd_row_q     <= '0;
      rd_done_q    <= 1'b0;
    end else if (cmd_i.push) begin
      full_q <= (row == last_row) && (col == last_col);
      if (col == last_col) begin
        wr_col_q <= '0;
        wr_row_q <= row + RowW'(1);
      end else begin
        wr_col_q <= col + ColW'(1);
        wr_row_q <= row;
      end
      if (full_q) begin
        rd_col_q  <= '0;
        rd_row_q  <= '0;
        rd_done_q <= 1'b0;
      end
      if (is_white) begin
        found_q <= 1'b1;
        if (!found_eff) begin
          box_top_q    <= row;
          box_bottom_q <= row;
          box_left_q   <= col;
          box_right_q  <= col;
        end else begin
          if (row < box_top_q)    box_top_q    <= row;
          if (row > box_bottom_q) box_bottom_q <= row;
          if (col < box_left_q)   box_left_q   <= col;
          if (col > box_right_q)  box_right_q  <= col;
        end
      end else if (full_q) begin
        found_q      <= 1'b0;
        box_top_q    <= last_row;
        box_bottom_q <= '0;
        box_left_q   <= last_col;
        box_right_q  <= '0;
      end
    end else if (cmd_i.pull && pull_status == StatusOk) begin
      if (col_end && row_end) begin
        rd_done_q <= 1'b1;
      end else if (col_end) begin
        rd_col_q <= '0;
        rd_row_q <= rd_row_q + RowW'(1);
      end else begin
        rd_col_q <= rd_col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pull) begin
      pend_status_q <= pull_status;
      pend_x_q      <= (pull_status == StatusOk) ? rd_col_q : '0;
      pend_y_q      <= (pull_status == StatusOk) ? rd_row_q : '0;
      pend_last_q   <= (pull_status == StatusOk) && col_end && row_end;
      pend_cw_q     <= (pull_status == StatusOk || pull_status == StatusDrained) ? cw : '0;
      pend_ch_q     <= (pull_status == StatusOk || pull_status == StatusDrained) ? ch : '0;
    end
    if (cmd_i.load_out) begin
      out_pixel_q  <= (pend_status_q == StatusOk) ? recolor(ram_rdata) : '0;
      out_x_q      <= pend_x_q;
      out_y_q      <= pend_y_q;
      out_last_q   <= pend_last_q;
      out_cw_q     <= pend_cw_q;
      out_ch_q     <= pend_ch_q;
      out_status_q <= pend_status_q;
    end
  end

  assign out_pixel_o   = out_pixel_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_last_o    = out_last_q;
  assign crop_width_o  = out_cw_q;
  assign crop_height_o = out_ch_q;
  assign status_o      = out_status_q;

endmodule

@@ design/bounding_box_crop_recolor_core.sv @@
// Stores one RGB888 frame pushed in raster order and tracks the bounding box of
// its pure white pixels; each pull then returns the next pixel of that box in
// raster order, recolored (green and black to white, white to black). A raster
// source can stream a pixel every cycle while no result waits. A pull does a
// registered read of the frame memory and then loads the output register. The
// input is held off while the output register is loaded and whenever it holds a
// result that is not being taken, so after a pull the next push or pull is
// accepted at the earliest in the cycle its result is taken.
// Writing frame_width or frame_height restarts the frame; a pull on an incomplete
// frame, on a frame with no white pixel, or after the last box pixel reports that
// in status.
module bounding_box_crop_recolor_core import bbcr_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  bbcr_in_if.sink   in_if,
  bbcr_out_if.source out_if,
  bbcr_cfg_if.sink  cfg_if
);

  cmd_t    cmd;
  status_e status;

  assign cfg_if.ready = 1'b1;

  bbcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_op_i     (in_if.op),
    .out_ready_i (out_if.ready),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .cmd_o       (cmd)
  );

  bbcr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .pixel_i       (in_if.pixel),
    .cfg_we_i      (cfg_if.valid && cfg_if.ready),
    .cfg_index_i   (cfg_if.index),
    .cfg_data_i    (cfg_if.data),
    .out_pixel_o   (out_if.out_pixel),
    .out_x_o       (out_if.out_x),
    .out_y_o       (out_if.out_y),
    .out_last_o    (out_if.last),
    .crop_width_o  (out_if.crop_width),
    .crop_height_o (out_if.crop_height),
    .status_o      (status)
  );

  assign out_if.status = status;

  a_load_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_if.valid)
    else $error("output register loaded but valid not raised");

  a_pull_blocks_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && in_if.op == OpPull) |=> !in_if.ready)
    else $error("input accepted while a pull is reading the store");

  a_ok_has_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.status == StatusOk) |->
      (out_if.crop_width != '0 && out_if.crop_height != '0))
    else $error("ok result with an empty box");

  a_last_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.last) |-> (out_if.status == StatusOk))
    else $error("last flag on a non-ok result");

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbcr_pkg::*;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [ColW-1:0] x;
    logic [RowW-1:0] y;
    logic            last;
    logic [DimW-1:0] cw;
    logic [DimW-1:0] ch;
    status_e         status;
  } crop_res_t;

  typedef enum logic [1:0] {
    RowPush,
    RowPull,
    RowCfg
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [PixW-1:0]    data;
    logic               chk;
    crop_res_t          lit;
  } dir_row_t;

  localparam crop_res_t NoRes = '0;
  localparam int unsigned DirRows = 28;

  // directed rows, literal result only where it is obvious
  localparam dir_row_t DirTab [DirRows] = '{
    '{RowPull, 8'h00, 24'hA5C3F0, 1'b1,
      '{24'h0, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, StatusIncomplete}},
    '{RowCfg, RegFrameWidth, 24'h000000, 1'b0, NoRes},
    '{RowCfg, RegFrameHeight, 24'h000000, 1'b0, NoRes},
    '{RowCfg, 8'hFF, 24'h000007, 1'b0, NoRes},
    '{RowPush, 8'h00, White, 1'b0, NoRes},
    '{RowPull, 8'h00, 24'hFFFFFF, 1'b1,
      '{Black, 7'd0, 7'd0, 1'b1, 8'd1, 8'd1, StatusOk}},
    '{RowPull, 8'h00, 24'h000000, 1'b1,
      '{24'h0, 7'd0, 7'd0, 1'b0, 8'd1, 8'd1, StatusDrained}},
    '{RowPush, 8'h00, Black, 1'b0, NoRes},
    '{RowPull, 8'h00, 24'h123456, 1'b1,
      '{24'h0, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, StatusEmpty}},
    '{RowCfg, RegFrameWidth, 24'd3, 1'b0, NoRes},
    '{RowCfg, RegFrameHeight, 24'd2, 1'b0, NoRes},
    '{RowPush, 8'h00, White, 1'b0, NoRes},
    '{RowPush, 8'h00, Green, 1'b0, NoRes},
    '{RowPull, 8'h00, 24'h0F0F0F, 1'b1,
      '{24'h0, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, StatusIncomplete}},
    '{RowPush, 8'h00, 24'h00FF01, 1'b0, NoRes},
    '{RowPush, 8'h00, 24'hFFFFFE, 1'b0, NoRes},
    '{RowPush, 8'h00, Black, 1'b0, NoRes},
    '{RowPush, 8'h00, White, 1'b0, NoRes},
    '{RowPull, 8'h00, 24'h800000, 1'b0, NoRes},
    '{RowPull, 8'h00, 24'h7FFFFF, 1'b0, NoRes},
    '{RowPull, 8'h00, 24'h000001, 1'b0, NoRes},
    '{RowPull, 8'h00, 24'hFF00FF, 1'b0, NoRes},
    '{RowPull, 8'h00, 24'h00FFFF, 1'b0, NoRes},
    '{RowPull, 8'h00, 24'hC0FFEE, 1'b0, NoRes},
    '{RowPull, 8'h00, 24'h333333, 1'b0, NoRes},
    '{RowCfg, RegFrameWidth, 24'h0000FF, 1'b0, NoRes},
    '{RowCfg, RegFrameHeight, 24'h000081, 1'b0, NoRes},
    '{RowPull, 8'h00, 24'hDEAD00, 1'b1,
      '{24'h0, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, StatusIncomplete}}
  };

  logic clk;
  logic rst_n;

  bbcr_in_if  in_bus ();
  bbcr_out_if out_bus ();
  bbcr_cfg_if cfg_bus ();

  bounding_box_crop_recolor_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  // shadow of the frame and of the box/readout tracking
  logic [PixW-1:0] shadow_mem [Depth];
  int unsigned     fr_w, fr_h, n_written;
  int unsigned     box_t, box_b, box_l, box_r;
  int unsigned     rd_col, rd_row;
  bit              box_seen, rd_fin;

  crop_res_t   pend_pixels [$];
  int unsigned n_items, n_checked, n_errors, n_phases;
  int unsigned status_seen [4];
  int unsigned hold_asked, hold_served;
  bit          rx_quiet, tx_quiet, tx_burst;

  function automatic void reset_frame_track();
    n_written = 0;
    box_t     = fr_h - 1;
    box_b     = 0;
    box_l     = fr_w - 1;
    box_r     = 0;
    box_seen  = 1'b0;
    rd_col    = 0;
    rd_row    = 0;
    rd_fin    = 1'b0;
  endfunction

  function automatic int unsigned fit_dim(logic [DimW-1:0] v, int unsigned lim);
    if (v == '0) begin
      return 1;
    end
    if (v > lim) begin
      return lim;
    end
    return v;
  endfunction

  function automatic void apply_cfg(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] val);
    if (idx == RegFrameWidth) begin
      fr_w = fit_dim(val, MaxWidth);
      reset_frame_track();
    end else if (idx == RegFrameHeight) begin
      fr_h = fit_dim(val, MaxHeight);
      reset_frame_track();
    end
  endfunction

  function automatic crop_res_t crop_recolor_step(logic op, logic [PixW-1:0] pix);
    crop_res_t       r;
    int unsigned     row, col, cw, ch;
    logic [PixW-1:0] src;
    r = '0;
    if (op == OpPush) begin
      if (n_written >= fr_w * fr_h) begin
        reset_frame_track();
      end
      row = n_written / fr_w;
      col = n_written % fr_w;
      shadow_mem[row * MaxWidth + col] = pix;
      if (pix == White) begin
        if (!box_seen) begin
          box_t    = row;
          box_b    = row;
          box_l    = col;
          box_r    = col;
          box_seen = 1'b1;
        end else begin
          if (row < box_t) box_t = row;
          if (row > box_b) box_b = row;
          if (col < box_l) box_l = col;
          if (col > box_r) box_r = col;
        end
      end
      n_written++;
      return r;
    end
    if (n_written < fr_w * fr_h) begin
      r.status = StatusIncomplete;
      return r;
    end
    if (!box_seen) begin
      r.status = StatusEmpty;
      return r;
    end
    cw   = box_r - box_l + 1;
    ch   = box_b - box_t + 1;
    r.cw = DimW'(cw);
    r.ch = DimW'(ch);
    if (rd_fin) begin
      r.status = StatusDrained;
      return r;
    end
    src = shadow_mem[(box_t + rd_row) * MaxWidth + box_l + rd_col];
    if (src == Green || src == Black) begin
      r.pixel = White;
    end else if (src == White) begin
      r.pixel = Black;
    end else begin
      r.pixel = src;
    end
    r.x = ColW'(rd_col);
    r.y = RowW'(rd_row);
    if (rd_col + 1 >= cw && rd_row + 1 >= ch) begin
      r.last = 1'b1;
      rd_fin = 1'b1;
    end else if (rd_col + 1 >= cw) begin
      rd_col = 0;
      rd_row++;
    end else begin
      rd_col++;
    end
    r.status = StatusOk;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_quiet || tx_burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [PixW-1:0] pick_pixel(int unsigned wpct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < wpct) begin
      return White;
    end else if (r < wpct + 8) begin
      return Green;
    end else if (r < wpct + 16) begin
      return Black;
    end else if (r < wpct + 22) begin
      // one bit away from a recolored value
      return (r[0] ? White : Green) ^ (PixW'(1) << $urandom_range(0, PixW - 1));
    end
    return PixW'($urandom);
  endfunction

  task automatic send_item(logic op, logic [PixW-1:0] pix, logic chk, crop_res_t lit);
    int unsigned gap;
    crop_res_t   r;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.op    <= op;
    in_bus.pixel <= pix;
    do @(posedge clk); while (!in_bus.ready);
    r = crop_recolor_step(op, pix);
    if (op == OpPull) begin
      pend_pixels.push_back(chk ? lit : r);
    end
    n_items++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    apply_cfg(idx, val);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // block drained: nothing pending and a pull that might still be in flight done
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pend_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d pulls pending", pend_pixels.size());
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls, quiet stretches, a long hold on each request
  initial begin
    int unsigned hold_left, stall_left, r;
    hold_left  = 0;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (rx_quiet) begin
        stall_left = 0;
        out_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_bus.ready <= 1'b1;
        end else begin
          stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(8, 30);
          out_bus.ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    crop_res_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pend_pixels.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, got pixel %h status %0d",
                 $time, out_bus.out_pixel, out_bus.status);
      end else begin
        e = pend_pixels.pop_front();
        n_checked++;
        status_seen[e.status]++;
        check_field("out_pixel", e.pixel, out_bus.out_pixel);
        check_field("out_x", e.x, out_bus.out_x);
        check_field("out_y", e.y, out_bus.out_y);
        check_field("last", e.last, out_bus.last);
        check_field("crop_width", e.cw, out_bus.crop_width);
        check_field("crop_height", e.ch, out_bus.crop_height);
        check_field("status", e.status, out_bus.status);
      end
    end
  end

  initial begin
    int unsigned     base_items, total, n_pull, wpct, frames, sel, wsel, lim;
    logic [DimW-1:0] raw_w, raw_h;
    logic [PixW-1:0] px;
    bit              corners;
    in_bus.valid  <= 1'b0;
    in_bus.op     <= OpPush;
    in_bus.pixel  <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data  <= '0;
    rst_n         <= 1'b0;
    fr_w = MaxWidth;
    fr_h = MaxHeight;
    reset_frame_track();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirRows; i++) begin
      if (DirTab[i].kind == RowCfg) begin
        wait_idle();
        write_reg(DirTab[i].idx, DirTab[i].data[DimW-1:0]);
      end else begin
        send_item((DirTab[i].kind == RowPull) ? OpPull : OpPush, DirTab[i].data,
                  DirTab[i].chk, DirTab[i].lit);
      end
    end
    base_items = n_items;

    while (n_items < base_items + 800) begin
      n_phases++;
      wait_idle();
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      sel      = $urandom_range(0, 39);
      corners  = ($urandom_range(0, 3) == 0);
      if (n_phases == 1) begin
        raw_w   = 8'd128;
        raw_h   = 8'd1;
        corners = 1'b1;
      end else if (n_phases == 2) begin
        raw_w   = 8'd1;
        raw_h   = 8'd128;
        corners = 1'b1;
      end else if (sel == 0) begin
        raw_w = DimW'($urandom_range(100, 255));
        raw_h = DimW'($urandom_range(0, 2));
      end else if (sel == 1) begin
        raw_w = DimW'($urandom_range(0, 2));
        raw_h = DimW'($urandom_range(100, 255));
      end else begin
        raw_w = DimW'($urandom_range(0, 9));
        raw_h = DimW'($urandom_range(0, 9));
      end
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CfgIdxW'($urandom_range(2, 255)), DimW'($urandom));
      end
      wsel = $urandom_range(0, 3);
      if (n_phases <= 2 || wsel != 1) write_reg(RegFrameWidth, raw_w);
      if (n_phases <= 2 || wsel != 0) write_reg(RegFrameHeight, raw_h);
      frames = (n_phases <= 2) ? 1 : $urandom_range(1, 3);
      repeat (frames) begin
        total = fr_w * fr_h;
        wpct  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(2, 40);
        for (int k = 0; k < total; k++) begin
          // stray pull in the middle of the frame
          if ($urandom_range(0, 29) == 0) begin
            send_item(OpPull, PixW'($urandom), 1'b0, NoRes);
          end
          if (corners && (k == 0 || k == total - 1)) begin
            px = White;
          end else begin
            px = pick_pixel(wpct);
          end
          send_item(OpPush, px, 1'b0, NoRes);
        end
        n_pull = box_seen ? (box_r - box_l + 1) * (box_b - box_t + 1) : 1;
        if (n_phases > 2 && $urandom_range(0, 4) == 0) begin
          // cut the readout short, the next push starts a new frame
          n_pull = $urandom_range(0, n_pull - 1);
        end else begin
          n_pull += $urandom_range(0, 2);
        end
        if (n_phases == 3) begin
          hold_asked++;
          tx_burst = 1'b1;
          if (n_pull < 24) n_pull = 24;
        end
        repeat (n_pull) send_item(OpPull, PixW'($urandom), 1'b0, NoRes);
        tx_burst = 1'b0;
      end
    end

    in_bus.valid <= 1'b0;
    lim = 0;
    while (pend_pixels.size() != 0 && lim < 20000) begin
      @(posedge clk);
      lim++;
    end
    repeat (8) @(posedge clk);
    if (pend_pixels.size() != 0) begin
      n_errors += pend_pixels.size();
      $display("%0t: %0d pulls never answered", $time, pend_pixels.size());
    end

    $display("%0d pushes and pulls (%0d directed) over %0d frame settings, %0d results checked",
             n_items, base_items, n_phases, n_checked);
    $display("status seen: ok %0d, incomplete %0d, empty %0d, drained %0d; %0d errors",
             status_seen[StatusOk], status_seen[StatusIncomplete], status_seen[StatusEmpty],
             status_seen[StatusDrained], n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/bbcr_pkg.sv
design/bbcr_if.sv
design/bbcr_ram.sv
design/bbcr_ctrl.sv
design/bbcr_datapath.sv
design/bounding_box_crop_recolor_core.sv
tb/tb.sv
